// ===== src/dbf_pkg.sv =====
// ----------------------------------------------------------------------------
// dbf_pkg: shared definitions for the DTS burst framer
// Header layout constants, status codes, register indexes and the command
// that travels from the front end to the word sequencer.
// ----------------------------------------------------------------------------
package dbf_pkg;

   localparam int HDR_BYTES = 10;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES + 1);
   localparam int HDR_PAIRS = HDR_BYTES / 2;
   localparam int PAIR_IDX_W = $clog2(HDR_PAIRS);
   localparam int CNT_W = 14;
   localparam int PAD_W = 12;

   // Command queue depth; keep it a power of two so the pointers wrap freely.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   localparam logic [31:0] SYNC_WORD   = 32'h7FFE8001;
   localparam logic [15:0] PREAMBLE_PA = 16'hF872;
   localparam logic [15:0] PREAMBLE_PB = 16'h4E1F;

   localparam logic [14:0] FSIZE_MIN = 15'd96;
   localparam logic [14:0] FSIZE_MAX = 15'd8192;

   // Block count field minus one for 16, 32 and 64 blocks
   localparam logic [6:0] NBLK_16 = 7'd15;
   localparam logic [6:0] NBLK_32 = 7'd31;
   localparam logic [6:0] NBLK_64 = 7'd63;

   // Burst length in words: two words per sample
   localparam logic [12:0] BURST_512  = 13'd1024;
   localparam logic [12:0] BURST_1024 = 13'd2048;
   localparam logic [12:0] BURST_2048 = 13'd4096;

   localparam logic [7:0] TC_512_RESET  = 8'd11;
   localparam logic [7:0] TC_1024_RESET = 8'd12;
   localparam logic [7:0] TC_2048_RESET = 8'd13;

   localparam logic [1:0] CSR_TC_512  = 2'd0;
   localparam logic [1:0] CSR_TC_1024 = 2'd1;
   localparam logic [1:0] CSR_TC_2048 = 2'd2;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_SYNC   = 3'd1;
   localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
   localparam logic [2:0] STATUS_BAD_BLOCKS = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG   = 3'd4;

   // Word positions inside a burst header
   localparam logic [3:0] STEP_PA    = 4'd0;
   localparam logic [3:0] STEP_PB    = 4'd1;
   localparam logic [3:0] STEP_TYPE  = 4'd2;
   localparam logic [3:0] STEP_LEN   = 4'd3;
   localparam logic [3:0] STEP_PAIR0 = 4'd4;
   localparam logic [3:0] STEP_LAST  = 4'd8;

   typedef struct packed {
      logic                   is_hdr;
      logic [15:0]            word;
      logic [2:0]             status;
      logic                   last;
      logic [7:0]             code;
      logic [8*HDR_BYTES-1:0] hdr;
   } dbf_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dbf_q_stat_type;

endpackage

// ===== src/dbf_req_if.sv =====
// ----------------------------------------------------------------------------
// dbf_req_if: source byte channel
// Carries one DTS byte or one pad request per beat.
// ----------------------------------------------------------------------------
interface dbf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, op, data_byte, input ready);
   modport sink (input valid, op, data_byte, output ready);
endinterface

// ===== src/dbf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dbf_rsp_if: burst word channel
// Carries one 16-bit burst word with its status per beat.
// ----------------------------------------------------------------------------
interface dbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] word;
   logic [2:0]  status;
   logic        last_of_burst;

   modport source (output valid, word, status, last_of_burst, input ready);
   modport sink (input valid, word, status, last_of_burst, output ready);
endinterface

// ===== src/dbf_front.sv =====
// ----------------------------------------------------------------------------
// dbf_front: beat intake and frame tracking
// Buffers and checks the frame header, pairs payload bytes, counts padding
// and posts one command per result-producing beat to the queue.
// ----------------------------------------------------------------------------
module dbf_front
   import dbf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_wdata,
   dbf_req_if.sink        req_ch,
   input  dbf_q_stat_type q_stat,
   output logic           push,
   output dbf_cmd_type    push_cmd
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_PAD
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]      frame_length_ff, frame_length_in;
   logic [PAD_W-1:0]      pad_left_ff, pad_left_in;
   logic [7:0]            held_ff, held_in;
   logic [7:0]            tc512_ff, tc1024_ff, tc2048_ff;
   logic [7:0]            hdr_ff [HDR_BYTES];

   logic                  take;
   logic                  hdr_we;
   logic [HDR_IDX_W-1:0]  hunt_idx, hunt_next;
   logic [31:0]           sync_word;
   logic [6:0]            nblk_code;
   logic [14:0]           fsize;
   logic [15:0]           used_words, pad_calc;
   logic [12:0]           burst_words;
   logic [7:0]            type_code;
   logic                  blk_ok;
   logic                  done;

   assign req_ch.ready = !q_stat.full;
   assign take = req_ch.valid && req_ch.ready;

   // Header fields; bytes 0..7 are already stored when the tenth arrives
   assign sync_word = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]};
   assign nblk_code = {hdr_ff[4][0], hdr_ff[5][7:2]};
   assign fsize = {1'b0, hdr_ff[5][1:0], hdr_ff[6], hdr_ff[7][7:4]} + 15'd1;
   assign used_words = 16'(({1'b0, fsize} + 16'd1) >> 1) + 16'd4;
   assign pad_calc = {3'b000, burst_words} - used_words;

   always_comb begin
      blk_ok = 1'b1;
      burst_words = BURST_512;
      type_code = tc512_ff;
      case (nblk_code)
         NBLK_16: begin
            burst_words = BURST_512;
            type_code = tc512_ff;
         end
         NBLK_32: begin
            burst_words = BURST_1024;
            type_code = tc1024_ff;
         end
         NBLK_64: begin
            burst_words = BURST_2048;
            type_code = tc2048_ff;
         end
         default: begin
            blk_ok = 1'b0;
         end
      endcase
   end

   assign hunt_idx = (byte_count_ff >= CNT_W'(HDR_BYTES)) ? '0 : byte_count_ff[HDR_IDX_W-1:0];
   assign hunt_next = hunt_idx + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      frame_length_in = frame_length_ff;
      pad_left_in = pad_left_ff;
      held_in = held_ff;
      hdr_we = 1'b0;
      done = 1'b0;
      push = 1'b0;
      push_cmd = '0;
      for (int i = 0; i < HDR_BYTES - 1; i++) begin
         push_cmd.hdr[8*(HDR_BYTES-i)-1 -: 8] = hdr_ff[i];
      end
      push_cmd.hdr[7:0] = req_ch.data_byte;
      push_cmd.status = STATUS_OK;
      if (take) begin
         case (phase_ff)
            PH_PAD: begin
               if (req_ch.op) begin
                  pad_left_in = pad_left_ff - 1'b1;
                  push = 1'b1;
                  if (pad_left_in == '0) begin
                     push_cmd.last = 1'b1;
                     phase_in = PH_HUNT;
                     byte_count_in = '0;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (!req_ch.op) begin
                  byte_count_in = byte_count_ff + 1'b1;
                  done = byte_count_in >= frame_length_ff;
                  if (byte_count_ff[0]) begin
                     push = 1'b1;
                     push_cmd.word = {held_ff, req_ch.data_byte};
                  end else if (done) begin
                     // odd frame: pair the trailing byte with zero
                     push = 1'b1;
                     push_cmd.word = {req_ch.data_byte, 8'h00};
                  end else begin
                     held_in = req_ch.data_byte;
                  end
                  if (done) begin
                     if (pad_left_ff == '0) begin
                        push_cmd.last = 1'b1;
                        phase_in = PH_HUNT;
                        byte_count_in = '0;
                     end else begin
                        phase_in = PH_PAD;
                     end
                  end
               end
            end
            default: begin
               if (!req_ch.op) begin
                  hdr_we = 1'b1;
                  byte_count_in = CNT_W'(hunt_next);
                  if (hunt_next == HDR_IDX_W'(HDR_BYTES)) begin
                     push = 1'b1;
                     phase_in = PH_HUNT;
                     byte_count_in = '0;
                     if (sync_word != SYNC_WORD) begin
                        push_cmd.status = STATUS_BAD_SYNC;
                     end else if (!hdr_ff[4][7] || fsize > FSIZE_MAX || fsize < FSIZE_MIN) begin
                        push_cmd.status = STATUS_BAD_HEADER;
                     end else if (!blk_ok) begin
                        push_cmd.status = STATUS_BAD_BLOCKS;
                     end else if (used_words > {3'b000, burst_words}) begin
                        push_cmd.status = STATUS_TOO_LONG;
                     end else begin
                        push_cmd.is_hdr = 1'b1;
                        push_cmd.word = {fsize[12:0], 3'b000};
                        push_cmd.code = type_code;
                        frame_length_in = fsize[CNT_W-1:0];
                        pad_left_in = pad_calc[PAD_W-1:0];
                        byte_count_in = CNT_W'(HDR_BYTES);
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         byte_count_ff <= '0;
         frame_length_ff <= '0;
         pad_left_ff <= '0;
         held_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         frame_length_ff <= frame_length_in;
         pad_left_ff <= pad_left_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc512_ff <= TC_512_RESET;
         tc1024_ff <= TC_1024_RESET;
         tc2048_ff <= TC_2048_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TC_512:  tc512_ff <= csr_wdata;
            CSR_TC_1024: tc1024_ff <= csr_wdata;
            CSR_TC_2048: tc2048_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[hunt_idx[HDR_IDX_W-1:0]] <= req_ch.data_byte;
      end
   end

`ifndef ASSERT_OFF
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |->
         byte_count_ff >= CNT_W'(HDR_BYTES) && byte_count_ff < frame_length_ff)
      else $error("payload byte count outside the frame");
`endif

endmodule

// ===== src/dbf_queue.sv =====
// ----------------------------------------------------------------------------
// dbf_queue: command queue between front end and word sequencer
// Small register FIFO; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module dbf_queue
   import dbf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  dbf_cmd_type    push_cmd,
   input  logic           pop,
   output dbf_cmd_type    head,
   output dbf_q_stat_type q_stat
);

   dbf_cmd_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;

   assign head = entry_ff[rd_ptr_ff];
   assign q_stat.full = count_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign q_stat.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("command pushed into a full queue");
`endif

`ifndef ASSERT_OFF
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("command popped from an empty queue");
`endif

endmodule

// ===== src/dbf_back.sv =====
// ----------------------------------------------------------------------------
// dbf_back: burst word sequencer
// Expands header commands into nine words, passes single words through,
// and holds each word in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module dbf_back
   import dbf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  dbf_q_stat_type q_stat,
   input  dbf_cmd_type    head,
   output logic           pop,
   dbf_rsp_if.source      rsp_ch
);

   logic [3:0]            step_ff, step_in;
   logic                  valid_ff, valid_in;
   logic [15:0]           word_ff;
   logic [2:0]            status_ff;
   logic                  last_ff;
   logic                  out_free;
   logic                  load;
   logic [15:0]           next_word;
   logic [PAIR_IDX_W-1:0] pair_idx;
   logic [15:0]           pairs [HDR_PAIRS];

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load = out_free && !q_stat.empty;
   assign pop = load && (!head.is_hdr || step_ff == STEP_LAST);
   assign pair_idx = PAIR_IDX_W'(step_ff - STEP_PAIR0);

   always_comb begin
      for (int i = 0; i < HDR_PAIRS; i++) begin
         pairs[i] = head.hdr[8*HDR_BYTES-1-16*i -: 16];
      end
   end

   always_comb begin
      case (step_ff)
         STEP_PA:   next_word = PREAMBLE_PA;
         STEP_PB:   next_word = PREAMBLE_PB;
         STEP_TYPE: next_word = {8'h00, head.code};
         STEP_LEN:  next_word = head.word;
         default:   next_word = pairs[pair_idx];
      endcase
      if (!head.is_hdr) begin
         next_word = head.word;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (load && head.is_hdr) begin
         step_in = (step_ff == STEP_LAST) ? STEP_PA : step_ff + 1'b1;
      end
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_PA;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= next_word;
         status_ff <= head.is_hdr ? STATUS_OK : head.status;
         last_ff <= head.is_hdr ? 1'b0 : head.last;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.word = word_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.last_of_burst = last_ff;

`ifndef ASSERT_OFF
   a_step_on_header: assert property (@(posedge clock) disable iff (reset)
      step_ff != STEP_PA |-> !q_stat.empty && head.is_hdr)
      else $error("header step running without a header command at the head");
`endif

endmodule

// ===== src/dts_burst_framer.sv =====
// Path: an accepted beat's result word goes into the command queue, then the output register.
// Throughput: one request beat per cycle while the four-entry command queue has room;
// one response beat per cycle while the sink is ready; a header beat expands to nine words.
// The response rate of the word sequencer sets the sustained figure.
// Reset: synchronous, active high; clears control state, restores the type codes
// to 11, 12 and 13; the header buffer needs no clearing and is written before use.
// ----------------------------------------------------------------------------
// dts_burst_framer: IEC 61937 burst framing of a DTS core byte stream
// Front end checks headers and pairs bytes, a short command queue decouples
// it from the sequencer that emits preambles, payload and padding words.
// ----------------------------------------------------------------------------
module dts_burst_framer
   import dbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   dbf_req_if.sink    req_ch,
   dbf_rsp_if.source  rsp_ch
);

   // Commands flow front -> queue -> sequencer
   dbf_cmd_type    push_cmd;
   dbf_cmd_type    head;
   dbf_q_stat_type q_stat;
   logic           push;
   logic           pop;

   // Accept beats, track the frame, post commands; stall only on a full queue
   dbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Absorb the nine-word header bursts while intake keeps running
   dbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   // Emit one word per cycle; hold it in the output register while stalled
   dbf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== tb/sv/dts_burst_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_burst_framer_tb: self-checking bench for the DTS burst framer
// Feeds DTS byte streams and pad requests, predicts every burst word with an
// in-bench model of the framer and checks each word, status and last flag.
// A table of frames covers the header errors, size limits and burst fits,
// then random frames run under three type code settings.
// ----------------------------------------------------------------------------
module dts_burst_framer_tb;
   import dbf_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int SETTLE_CYCLES   = 16;    // covers the output register plus the queue
   localparam int HOLDOFF_AT_WORD = 3000;
   localparam int HOLDOFF_CYCLES  = 600;
   localparam int RANDOM_FRAMES   = 8;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_PAD  = 1'b1;

   typedef enum logic [1:0] {FR_HUNT, FR_PAYLOAD, FR_PAD} framer_phase_type;

   typedef struct packed {
      logic [15:0] word;
      logic [2:0]  status;
      logic        last;
   } burst_word_type;

   // One frame to send: header fields (size and block count minus one, as coded)
   // and, for error rows, the single status word typed in by hand.
   typedef struct packed {
      logic [31:0] sync;
      logic        ftype;
      logic [6:0]  nblk_m1;
      logic [13:0] fsize_m1;
      logic        pinned;
      logic [2:0]  pin_status;
      logic        noisy;
   } frame_spec_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_TC_512;
   logic [7:0] csr_wdata = 8'h00;

   dbf_req_if req_bus ();
   dbf_rsp_if rsp_bus ();

   dts_burst_framer u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Framer prediction state
   // ------------------------------------------------------------------------
   logic [7:0]       tc_512, tc_1024, tc_2048;
   logic [7:0]       hdr_seen [HDR_BYTES];
   logic [13:0]      frame_count;
   logic [13:0]      frame_len;
   logic [11:0]      pads_owed;
   framer_phase_type phase_now;
   logic [7:0]       held_hi;

   burst_word_type words_due [$];   // burst words still owed by the block, oldest first
   burst_word_type words_new [$];   // words released by the last accepted beat
   int             mismatches = 0;
   int             words_seen = 0;
   int             burst_left = 0;

   frame_spec_type directed_rows [16];

   function automatic void note_word(input logic [15:0] w, input logic [2:0] s,
                                     input logic l);
      burst_word_type bw;
      bw.word = w;
      bw.status = s;
      bw.last = l;
      words_new.push_back(bw);
   endfunction

   function automatic void restart_hunt();
      phase_now = FR_HUNT;
      frame_count = '0;
   endfunction

   // Tenth header byte in: run the checks in order sync, type and size, blocks, fit.
   function automatic void check_header();
      logic [31:0] sync;
      logic [6:0]  nblk_m1;
      logic [7:0]  code;
      int          fsize, burst, used;
      sync = {hdr_seen[0], hdr_seen[1], hdr_seen[2], hdr_seen[3]};
      nblk_m1 = {hdr_seen[4][0], hdr_seen[5][7:2]};
      fsize = int'({hdr_seen[5][1:0], hdr_seen[6], hdr_seen[7][7:4]}) + 1;
      restart_hunt();
      burst = 0;
      code = 8'h00;
      case (nblk_m1)
         NBLK_16: begin burst = BURST_512;  code = tc_512;  end
         NBLK_32: begin burst = BURST_1024; code = tc_1024; end
         NBLK_64: begin burst = BURST_2048; code = tc_2048; end
         default: ;
      endcase
      used = 4 + (fsize + 1) / 2;
      if (sync != SYNC_WORD) begin
         note_word(16'h0000, STATUS_BAD_SYNC, 1'b0);
      end else if (!hdr_seen[4][7] || fsize > FSIZE_MAX || fsize < FSIZE_MIN) begin
         note_word(16'h0000, STATUS_BAD_HEADER, 1'b0);
      end else if (burst == 0) begin
         note_word(16'h0000, STATUS_BAD_BLOCKS, 1'b0);
      end else if (used > burst) begin
         note_word(16'h0000, STATUS_TOO_LONG, 1'b0);
      end else begin
         frame_len = 14'(fsize);
         pads_owed = 12'(burst - used);
         note_word(PREAMBLE_PA, STATUS_OK, 1'b0);
         note_word(PREAMBLE_PB, STATUS_OK, 1'b0);
         note_word({8'h00, code}, STATUS_OK, 1'b0);
         note_word(16'(fsize * 8), STATUS_OK, 1'b0);
         for (int i = 0; i < HDR_PAIRS; i++)
            note_word({hdr_seen[2*i], hdr_seen[2*i+1]}, STATUS_OK, 1'b0);
         frame_count = 14'(HDR_BYTES);
         phase_now = FR_PAYLOAD;
      end
   endfunction

   // Advance the prediction by one accepted beat; released words land in words_new.
   function automatic void framer_predict(input logic op, input logic [7:0] b);
      logic [13:0] idx;
      logic [15:0] w;
      logic        done;
      words_new.delete();
      case (phase_now)
         FR_PAD: begin
            // bytes are dropped here; each pad request owes one zero word
            if (op == OP_PAD) begin
               pads_owed = pads_owed - 1'b1;
               if (pads_owed == '0) begin
                  restart_hunt();
                  note_word(16'h0000, STATUS_OK, 1'b1);
               end else begin
                  note_word(16'h0000, STATUS_OK, 1'b0);
               end
            end
         end
         FR_PAYLOAD: begin
            if (op == OP_BYTE) begin
               idx = frame_count;
               frame_count = idx + 1'b1;
               done = (frame_count >= frame_len);
               if (idx[0] || done) begin
                  // an odd trailing byte goes out high with a zero low half
                  w = idx[0] ? {held_hi, b} : {b, 8'h00};
                  if (!done) begin
                     note_word(w, STATUS_OK, 1'b0);
                  end else if (pads_owed == '0) begin
                     restart_hunt();
                     note_word(w, STATUS_OK, 1'b1);
                  end else begin
                     phase_now = FR_PAD;
                     note_word(w, STATUS_OK, 1'b0);
                  end
               end else begin
                  held_hi = b;
               end
            end
         end
         default: begin
            if (op == OP_BYTE) begin
               if (frame_count >= HDR_BYTES)
                  frame_count = '0;
               hdr_seen[frame_count] = b;
               frame_count = frame_count + 1'b1;
               if (frame_count == HDR_BYTES)
                  check_header();
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side: bursts of beats separated by random gaps
   // ------------------------------------------------------------------------
   task automatic offer_beat(input logic op, input logic [7:0] b, input logic pinned,
                             input logic [2:0] pin_status);
      int             gap;
      burst_word_type bw;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         // now and then run a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // beat taken at this edge: advance the prediction
      framer_predict(op, b);
      if (pinned) begin
         bw.word = 16'h0000;
         bw.status = pin_status;
         bw.last = 1'b0;
         words_due.push_back(bw);
      end else begin
         foreach (words_new[i]) words_due.push_back(words_new[i]);
      end
   endtask

   // Hold the sender until every owed word is out, then let the pipe settle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_TC_512:  tc_512 = v;
         CSR_TC_1024: tc_1024 = v;
         CSR_TC_2048: tc_2048 = v;
         default: ;
      endcase
   endtask

   task automatic load_type_codes(input logic [7:0] c512, input logic [7:0] c1024,
                                  input logic [7:0] c2048);
      wait_drained();
      csr_write(CSR_TC_512, c512);
      csr_write(CSR_TC_1024, c1024);
      csr_write(CSR_TC_2048, c2048);
      csr_we <= 1'b0;
   endtask

   // Send one frame: ten header bytes, then bytes while the framer is in payload
   // and pad requests while it pads. Sprinkle ignored beats on the way.
   task automatic send_frame(input frame_spec_type f);
      logic [7:0] hb [HDR_BYTES];
      hb[0] = f.sync[31:24];
      hb[1] = f.sync[23:16];
      hb[2] = f.sync[15:8];
      hb[3] = f.sync[7:0];
      hb[4] = {f.ftype, 6'($urandom), f.nblk_m1[6]};
      hb[5] = {f.nblk_m1[5:0], f.fsize_m1[13:12]};
      hb[6] = f.fsize_m1[11:4];
      hb[7] = {f.fsize_m1[3:0], 4'($urandom)};
      hb[8] = 8'($urandom);
      hb[9] = 8'($urandom);
      // pad request while hunting: dropped
      if (f.noisy)
         offer_beat(OP_PAD, 8'($urandom), 1'b0, STATUS_OK);
      for (int i = 0; i < HDR_BYTES; i++)
         offer_beat(OP_BYTE, hb[i], f.pinned && i == HDR_BYTES - 1, f.pin_status);
      // pad request in payload: dropped
      if (f.noisy && phase_now == FR_PAYLOAD)
         offer_beat(OP_PAD, 8'($urandom), 1'b0, STATUS_OK);
      while (phase_now == FR_PAYLOAD) begin
         if ($urandom_range(0, 49) == 0)
            offer_beat(OP_PAD, 8'($urandom), 1'b0, STATUS_OK);
         if ($urandom_range(0, 399) == 0)
            wait_drained();
         offer_beat(OP_BYTE, 8'($urandom), 1'b0, STATUS_OK);
      end
      // source byte while padding: dropped
      if (f.noisy && phase_now == FR_PAD)
         offer_beat(OP_BYTE, 8'($urandom), 1'b0, STATUS_OK);
      while (phase_now == FR_PAD) begin
         if ($urandom_range(0, 49) == 0)
            offer_beat(OP_BYTE, 8'($urandom), 1'b0, STATUS_OK);
         offer_beat(OP_PAD, 8'($urandom), 1'b0, STATUS_OK);
      end
   endtask

   // Mostly well-formed frames with short sizes; the rest break one header field.
   function automatic frame_spec_type pick_frame();
      frame_spec_type f;
      int             burst, pick;
      logic [6:0]     nb;
      f.sync = SYNC_WORD;
      f.ftype = 1'b1;
      f.pinned = 1'b0;
      f.pin_status = STATUS_OK;
      f.noisy = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
         f.nblk_m1 = NBLK_16;
         burst = BURST_512;
      end else if (pick < 19) begin
         f.nblk_m1 = NBLK_32;
         burst = BURST_1024;
      end else begin
         f.nblk_m1 = NBLK_64;
         burst = BURST_2048;
      end
      // once in a while fill the burst exactly, so no padding follows
      if ($urandom_range(0, 9) == 0)
         f.fsize_m1 = 14'(2 * (burst - 4) - 1 - $urandom_range(0, 1));
      else
         f.fsize_m1 = 14'(95 + $urandom_range(0, 64));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         case (pick % 6)
            0: f.sync = SYNC_WORD ^ (32'h1 << $urandom_range(0, 31));
            1: f.ftype = 1'b0;
            2: f.fsize_m1 = 14'($urandom_range(0, 94));
            3: f.fsize_m1 = 14'($urandom_range(8192, 16383));
            4: begin
               nb = 7'($urandom);
               if (nb == NBLK_16 || nb == NBLK_32 || nb == NBLK_64)
                  nb = nb + 1'b1;
               f.nblk_m1 = nb;
            end
            default: begin
               f.nblk_m1 = NBLK_16;
               f.fsize_m1 = 14'($urandom_range(2040, 8191));
            end
         endcase
      end
      return f;
   endfunction

   task automatic random_frames(input int count);
      repeat (count) begin
         // noise: stray pad requests, then a partial header filled up to ten bytes
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) offer_beat(OP_PAD, 8'($urandom), 1'b0, STATUS_OK);
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 9)) offer_beat(OP_BYTE, 8'($urandom), 1'b0, STATUS_OK);
         while (phase_now == FR_HUNT && frame_count != '0)
            offer_beat(OP_BYTE, 8'($urandom), 1'b0, STATUS_OK);
         send_frame(pick_frame());
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: stall patterns, plus one long hold-off that backs the
   // command queue up and stalls the request side
   // ------------------------------------------------------------------------
   initial begin
      int         stretch, mode, k;
      logic [7:0] pat;
      logic       r;
      bit         held_done;
      rsp_bus.ready = 1'b0;
      stretch = 0;
      mode = 0;
      k = 0;
      pat = 8'hFF;
      held_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_done && words_seen >= HOLDOFF_AT_WORD) begin
            held_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(16, 200);
               mode = $urandom_range(0, 3);
               pat = 8'($urandom);
            end
            stretch--;
            k++;
            case (mode)
               0: r = 1'b1;
               1: r = 1'($urandom_range(0, 1));
               2: r = ($urandom_range(0, 6) != 0);
               default: r = pat[k % 8];
            endcase
            rsp_bus.ready <= r;
         end
      end
   end

   // Check every accepted word against the oldest owed one.
   always @(posedge clock) begin
      burst_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         if (words_due.size() == 0) begin
            mismatches++;
            $display("%0t: word %h status %0d last %0b with nothing owed", $time,
                     rsp_bus.word, rsp_bus.status, rsp_bus.last_of_burst);
         end else begin
            due = words_due.pop_front();
            if (rsp_bus.word !== due.word) begin
               mismatches++;
               $display("%0t: word expected %h actual %h", $time, due.word, rsp_bus.word);
            end
            if (rsp_bus.status !== due.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d", $time, due.status,
                        rsp_bus.status);
            end
            if (rsp_bus.last_of_burst !== due.last) begin
               mismatches++;
               $display("%0t: last expected %0b actual %0b", $time, due.last,
                        rsp_bus.last_of_burst);
            end
         end
      end
   end

   // Cycle guard
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = OP_BYTE;
      req_bus.data_byte = 8'h00;
      tc_512 = TC_512_RESET;
      tc_1024 = TC_1024_RESET;
      tc_2048 = TC_2048_RESET;
      foreach (hdr_seen[i]) hdr_seen[i] = 8'h00;
      frame_count = '0;
      frame_len = '0;
      pads_owed = '0;
      phase_now = FR_HUNT;
      held_hi = 8'h00;

      // Directed frames: sync, frame type, size, block count, burst fit,
      // then good frames at the size and burst extremes
      directed_rows = '{
         // all ones header, pad request while hunting first
         '{32'hFFFF_FFFF, 1'b1, 7'h7F, 14'h3FFF, 1'b1, STATUS_BAD_SYNC, 1'b1},
         '{32'h0000_0000, 1'b0, 7'h00, 14'h0000, 1'b1, STATUS_BAD_SYNC, 1'b0},
         // frame type zero
         '{SYNC_WORD, 1'b0, NBLK_16, 14'd95, 1'b1, STATUS_BAD_HEADER, 1'b0},
         // 95 bytes, one short of the minimum
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd94, 1'b1, STATUS_BAD_HEADER, 1'b0},
         // 8193 bytes, one over the maximum
         '{SYNC_WORD, 1'b1, NBLK_64, 14'd8192, 1'b1, STATUS_BAD_HEADER, 1'b0},
         '{SYNC_WORD, 1'b1, NBLK_16, 14'h3FFF, 1'b1, STATUS_BAD_HEADER, 1'b0},
         // one block, 128 blocks
         '{SYNC_WORD, 1'b1, 7'h00, 14'd95, 1'b1, STATUS_BAD_BLOCKS, 1'b0},
         '{SYNC_WORD, 1'b1, 7'h7F, 14'd95, 1'b1, STATUS_BAD_BLOCKS, 1'b0},
         // one word too many for a 1024-word burst
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd2040, 1'b1, STATUS_TOO_LONG, 1'b0},
         // largest legal size still too long for the largest burst
         '{SYNC_WORD, 1'b1, NBLK_64, 14'd8191, 1'b1, STATUS_TOO_LONG, 1'b0},
         // smallest frame, with dropped beats in payload and padding
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd95, 1'b0, STATUS_OK, 1'b1},
         // odd size: trailing byte paired with zero
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd96, 1'b0, STATUS_OK, 1'b0},
         // payload fills the burst, no padding
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd2039, 1'b0, STATUS_OK, 1'b0},
         '{SYNC_WORD, 1'b1, NBLK_16, 14'd2038, 1'b0, STATUS_OK, 1'b1},
         '{SYNC_WORD, 1'b1, NBLK_32, 14'd95, 1'b0, STATUS_OK, 1'b0},
         // 8184 bytes fill a 4096-word burst
         '{SYNC_WORD, 1'b1, NBLK_64, 14'd8183, 1'b0, STATUS_OK, 1'b0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) send_frame(directed_rows[r]);

      // Random frames under three type code settings, extremes first
      load_type_codes(8'h00, 8'hFF, 8'($urandom));
      random_frames(RANDOM_FRAMES);
      load_type_codes(8'hFF, 8'h00, 8'($urandom));
      random_frames(RANDOM_FRAMES);
      load_type_codes(8'($urandom), 8'($urandom), 8'($urandom));
      random_frames(RANDOM_FRAMES);

      wait_drained();
      if (mismatches == 0 && words_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== dts_burst_framer.f =====
src/dbf_pkg.sv
src/dbf_req_if.sv
src/dbf_rsp_if.sv
src/dbf_front.sv
src/dbf_queue.sv
src/dbf_back.sv
src/dts_burst_framer.sv
tb/sv/dts_burst_framer_tb.sv
